FILE: rtl/core/cnm_pkg.sv
// Shared constants, types and helpers for the name matcher.
`timescale 1ns / 1ps

package cnm_pkg;

    // Pattern table geometry
    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int WINDOW_CELLS    = MAX_PATTERN_LEN - 1;
    localparam int LEN_W           = 4;
    localparam int CHAR_IDX_W      = 3;

    // Configuration port
    localparam int REG_COUNT   = 2 * NUM_PATTERNS;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int DESC_W      = 20;

    // Register kind, taken from the low bit of the register index
    localparam logic REG_KIND_BYTES = 1'b0;
    localparam logic REG_KIND_DESC  = 1'b1;

    // Descriptor field positions
    localparam int DESC_LEN_LSB   = 0;
    localparam int DESC_CLASS_LSB = 4;
    localparam int DESC_CAT_LSB   = 12;

    // Reset contents of entry 0
    localparam logic [CFG_DATA_W-1:0] ENTRY0_BYTES_RESET = 64'h0000_006B_636F_6C66;
    localparam logic [DESC_W-1:0]     ENTRY0_DESC_RESET  = 20'd5;

    // ASCII case folding
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef logic [7:0] char_t;
    typedef logic [NUM_PATTERNS-1:0] entry_vec_t;

    // Control handed from the top level to every window cell
    typedef struct packed {
        logic advance;
        logic flush;
    } cell_ctrl_t;

    function automatic char_t fold_case(input char_t c);
        char_t r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // Folded pattern character at a given position
    function automatic char_t pattern_char(input logic [CFG_DATA_W-1:0] bytes,
                                           input logic [CHAR_IDX_W-1:0] idx);
        return fold_case(bytes[idx*8 +: 8]);
    endfunction

endpackage

FILE: rtl/core/cnm_cell.sv
// One window cell: holds one folded name byte and compares it for every entry.
`timescale 1ns / 1ps

module cnm_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cnm_pkg::cell_ctrl_t           ctrl,
    input  cnm_pkg::char_t                byte_in,
    input  logic                          valid_in,
    input  cnm_pkg::char_t [cnm_pkg::NUM_PATTERNS-1:0] expect_char,
    input  cnm_pkg::entry_vec_t           need,
    output cnm_pkg::char_t                byte_out,
    output logic                          valid_out,
    output cnm_pkg::entry_vec_t           match
);
    import cnm_pkg::*;

    char_t byte_reg;
    logic  valid_reg;

    // Take the neighbor's byte on each request; drop the byte at the end of a name
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            valid_reg <= ctrl.flush ? 1'b0 : valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            byte_reg <= byte_in;
        end
    end

    // Pass when this position is outside the pattern or holds the expected byte
    always_comb begin
        for (int e = 0; e < NUM_PATTERNS; e++) begin
            match[e] = !need[e] || (valid_reg && (byte_reg == expect_char[e]));
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

FILE: rtl/core/case_insensitive_name_matcher.sv
// Top level of the case-insensitive multi-pattern name matcher.
`timescale 1ns / 1ps

// Usage:
//   The input channel (s_valid/s_ready) takes one raw name byte per request,
//   with s_last_byte on the final byte of a name. Bytes are folded to lower
//   case and shifted through a row of seven window cells; each of four
//   pattern entries is compared against the window ending at every byte.
//   A hit is sticky until the end of the name.
//   The result channel (m_valid/m_ready) carries one request per name:
//   m_matched and the class and category of the lowest-numbered hit entry.
//   Throughput: one byte per cycle while s_ready is high, back to back.
//   Latency: the result is valid in the cycle after the final byte is taken.
//   The result sits in an output register; while it waits, s_ready stays
//   high only if m_ready takes it in the same cycle, so a stalled receiver
//   holds the input for at most as long as the result waits.
//   Reset clears the window, the hit flags and the output, and loads the
//   pattern registers with their defaults (entry 0 enabled, others off).
//   Write pattern registers (cfg_we/cfg_index/cfg_wdata) only while no name
//   is in progress; not enforced here. Indexes beyond the table are ignored.
module case_insensitive_name_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [cnm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cnm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_name_byte,
    input  logic                             s_last_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_matched,
    output logic [7:0]                       m_class_code,
    output logic [7:0]                       m_category_code
);
    import cnm_pkg::*;

    logic [CFG_DATA_W-1:0] pattern_bytes_reg [NUM_PATTERNS];
    logic [DESC_W-1:0]     pattern_desc_reg  [NUM_PATTERNS];

    entry_vec_t hits_reg;
    entry_vec_t hits_next;
    entry_vec_t new_hit;

    logic       m_valid_reg;
    logic       m_matched_reg;
    char_t      m_class_reg;
    char_t      m_category_reg;
    logic       result_found;
    char_t      result_class;
    char_t      result_category;

    logic       accept;
    cell_ctrl_t cell_ctrl;
    char_t      in_char;

    char_t      cell_byte  [WINDOW_CELLS];
    logic [WINDOW_CELLS-1:0] cell_valid;
    entry_vec_t cell_match [WINDOW_CELLS];

    char_t [NUM_PATTERNS-1:0] expect_char [MAX_PATTERN_LEN];
    entry_vec_t               need        [MAX_PATTERN_LEN];
    entry_vec_t               head_match;
    entry_vec_t               entry_on;

    // Handshake
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign in_char   = fold_case(s_name_byte);
    assign cell_ctrl = '{advance: accept, flush: s_last_byte};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < NUM_PATTERNS; e++) begin
                pattern_bytes_reg[e] <= (e == 0) ? ENTRY0_BYTES_RESET : '0;
                pattern_desc_reg[e]  <= (e == 0) ? ENTRY0_DESC_RESET : '0;
            end
        end else if (cfg_we && (int'(cfg_index) < REG_COUNT)) begin
            if (cfg_index[0] == REG_KIND_BYTES) begin
                pattern_bytes_reg[cfg_index[CFG_INDEX_W-2:1]] <= cfg_wdata;
            end else begin
                pattern_desc_reg[cfg_index[CFG_INDEX_W-2:1]] <= cfg_wdata[DESC_W-1:0];
            end
        end
    end

    // Expected byte and use flag per entry and window position
    always_comb begin
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] char_pos;
        for (int e = 0; e < NUM_PATTERNS; e++) begin
            len         = pattern_desc_reg[e][DESC_LEN_LSB +: LEN_W];
            entry_on[e] = (len != '0) && (int'(len) <= MAX_PATTERN_LEN);
            for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
                pos               = LEN_W'(p);
                char_pos          = len - pos - LEN_W'(1);
                need[p][e]        = pos < len;
                expect_char[p][e] = pattern_char(pattern_bytes_reg[e],
                                                 char_pos[CHAR_IDX_W-1:0]);
            end
        end
    end

    // Newest byte is compared here, before it enters the row
    always_comb begin
        for (int e = 0; e < NUM_PATTERNS; e++) begin
            head_match[e] = !need[0][e] || (in_char == expect_char[0][e]);
        end
    end

    // Row of window cells, newest byte at cell 0
    for (genvar c = 0; c < WINDOW_CELLS; c++) begin : g_cell
        cnm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .byte_in     ((c == 0) ? in_char : cell_byte[(c == 0) ? 0 : c - 1]),
            .valid_in    ((c == 0) ? 1'b1 : cell_valid[(c == 0) ? 0 : c - 1]),
            .expect_char (expect_char[c + 1]),
            .need        (need[c + 1]),
            .byte_out    (cell_byte[c]),
            .valid_out   (cell_valid[c]),
            .match       (cell_match[c])
        );
    end

    // Combine per-position results into a hit per entry
    always_comb begin
        entry_vec_t all_match;
        all_match = head_match;
        for (int c = 0; c < WINDOW_CELLS; c++) begin
            all_match = all_match & cell_match[c];
        end
        new_hit   = all_match & entry_on;
        hits_next = hits_reg | new_hit;
    end

    // Sticky hit flags, cleared at the end of each name
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg <= '0;
        end else if (accept) begin
            hits_reg <= s_last_byte ? '0 : hits_next;
        end
    end

    // Pick the lowest-numbered hit entry
    always_comb begin
        result_found    = 1'b0;
        result_class    = '0;
        result_category = '0;
        for (int e = NUM_PATTERNS - 1; e >= 0; e--) begin
            if (hits_next[e]) begin
                result_found    = 1'b1;
                result_class    = pattern_desc_reg[e][DESC_CLASS_LSB +: 8];
                result_category = pattern_desc_reg[e][DESC_CAT_LSB +: 8];
            end
        end
    end

    // Output register: load on the final byte, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            m_matched_reg  <= result_found;
            m_class_reg    <= result_class;
            m_category_reg <= result_category;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_matched       = m_matched_reg;
    assign m_class_code    = m_class_reg;
    assign m_category_code = m_category_reg;

    // A name that ends leaves an empty window and no hits behind
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> (cell_valid == '0 && hits_reg == '0))
        else $error("window or hit flags not cleared after final byte");

    // Valid window bytes fill from cell 0 without gaps
    a_window_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid & (cell_valid + WINDOW_CELLS'(1))) == '0))
        else $error("window valid bits not contiguous");

    // No match means empty class and category
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_matched) |-> (m_class_code == '0 && m_category_code == '0))
        else $error("class or category set without a match");

    // The final byte always produces a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> m_valid)
        else $error("final byte produced no result");

endmodule
